@@ rtl/core/qcvf_pkg.sv @@
// shared types, constants and the hit-count merge function of the concave vertex finder
package qcvf_pkg;

   localparam int NUM_CORNERS = 4;
   localparam int CORNER_IDX_W = 2;
   localparam logic [1:0] HIT_LIMIT = 2'd2;

   typedef struct packed {
      logic found;
      logic [CORNER_IDX_W-1:0] corner_index;
   } qcvf_result_type;

   // load enables of the three lane stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } qcvf_adv_type;

   // walk the corners in order; a flagged corner bumps itself and its successor,
   // and the first counter to reach the limit wins
   function automatic qcvf_result_type qcvf_merge_flags(input logic [NUM_CORNERS-1:0] flags);
      logic [1:0] hits [NUM_CORNERS];
      qcvf_result_type res;
      logic done;
      logic [CORNER_IDX_W-1:0] cur;
      logic [CORNER_IDX_W-1:0] nxt;
      res = '0;
      done = 1'b0;
      for (int c = 0; c < NUM_CORNERS; c++) begin
         hits[c] = 2'd0;
      end
      for (int k = 0; k < NUM_CORNERS; k++) begin
         cur = CORNER_IDX_W'(k);
         nxt = CORNER_IDX_W'(k + 1);
         if (!done && flags[k]) begin
            hits[cur] = hits[cur] + 2'd1;
            hits[nxt] = hits[nxt] + 2'd1;
            if (hits[cur] >= HIT_LIMIT) begin
               res.found = 1'b1;
               res.corner_index = cur;
               done = 1'b1;
            end else if (hits[nxt] >= HIT_LIMIT) begin
               res.found = 1'b1;
               res.corner_index = nxt;
               done = 1'b1;
            end
         end
      end
      return res;
   endfunction

endpackage

@@ rtl/core/qcvf_lane.sv @@
// one corner lane: edge vectors, exact cross products and the sign mismatch flag
module qcvf_lane
   import qcvf_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  qcvf_adv_type adv,
   input  logic signed [COORD_WIDTH-1:0] p0_x,
   input  logic signed [COORD_WIDTH-1:0] p0_y,
   input  logic signed [COORD_WIDTH-1:0] p1_x,
   input  logic signed [COORD_WIDTH-1:0] p1_y,
   input  logic signed [COORD_WIDTH-1:0] p2_x,
   input  logic signed [COORD_WIDTH-1:0] p2_y,
   input  logic signed [COORD_WIDTH-1:0] p3_x,
   input  logic signed [COORD_WIDTH-1:0] p3_y,
   output logic flag
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] bx_in, by_in, ax_in, ay_in, cx_in, cy_in;
   logic signed [DW-1:0] bx_ff, by_ff, ax_ff, ay_ff, cx_ff, cy_ff;
   logic signed [PW-1:0] m1a_in, m1b_in, m2a_in, m2b_in;
   logic signed [PW-1:0] m1a_ff, m1b_ff, m2a_ff, m2b_ff;
   logic flag_in, flag_ff;

   always_comb begin
      bx_in = {p0_x[COORD_WIDTH-1], p0_x} - {p1_x[COORD_WIDTH-1], p1_x};
      by_in = {p0_y[COORD_WIDTH-1], p0_y} - {p1_y[COORD_WIDTH-1], p1_y};
      ax_in = {p0_x[COORD_WIDTH-1], p0_x} - {p2_x[COORD_WIDTH-1], p2_x};
      ay_in = {p0_y[COORD_WIDTH-1], p0_y} - {p2_y[COORD_WIDTH-1], p2_y};
      cx_in = {p0_x[COORD_WIDTH-1], p0_x} - {p3_x[COORD_WIDTH-1], p3_x};
      cy_in = {p0_y[COORD_WIDTH-1], p0_y} - {p3_y[COORD_WIDTH-1], p3_y};
   end

   always_comb begin
      m1a_in = bx_ff * ay_ff;
      m1b_in = by_ff * ax_ff;
      m2a_in = bx_ff * cy_ff;
      m2b_in = by_ff * cx_ff;
   end

   // signs agree only when both the greater and the equal tests agree
   always_comb begin
      flag_in = ((m1a_ff > m1b_ff) != (m2a_ff > m2b_ff))
             || ((m1a_ff == m1b_ff) != (m2a_ff == m2b_ff));
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         bx_ff <= bx_in;
         by_ff <= by_in;
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
      if (adv.s2) begin
         m1a_ff <= m1a_in;
         m1b_ff <= m1b_in;
         m2a_ff <= m2a_in;
         m2b_ff <= m2b_in;
      end
      if (adv.s3) begin
         flag_ff <= flag_in;
      end
   end

   assign flag = flag_ff;

endmodule

@@ rtl/core/qcvf_merge.sv @@
// merge of the four lane flags into the registered result item
module qcvf_merge
   import qcvf_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic [NUM_CORNERS-1:0] flags,
   input  logic in_valid,
   input  logic out_ready,
   output logic advance,
   output logic out_valid,
   output qcvf_result_type result
);

   logic valid_ff, valid_in;
   qcvf_result_type result_ff, result_in;

   assign advance = !valid_ff || out_ready;
   assign valid_in = advance ? in_valid : valid_ff;
   assign result_in = qcvf_merge_flags(flags);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = valid_ff;
   assign result = result_ff;

endmodule

@@ rtl/core/quad_concave_vertex_finder.sv @@
// top level of the quadrilateral concave vertex finder
//
// the req channel carries one quadrilateral per item: eight signed coordinates
// p0_x, p0_y .. p3_x, p3_y packed from the low bits of req_tdata. the rsp
// channel returns one item per quad: rsp_tuser is the found flag and
// rsp_tdata[1:0] the index of the concave corner (zero when nothing found).
// four lanes, one per corner, form the edge vectors, multiply them out exactly
// and flag a sign mismatch between the two cross products; a merge stage then
// runs the hit counting over the four flags.
// from acceptance to rsp_tvalid an item passes the registered edge vectors, products,
// sign compare and merge. throughput is one item per cycle while rsp_tready is high;
// the four multipliers in each lane all work in the same product stage.
// when the receiver stalls, each stage holds and req_tready stays high while an
// empty stage is left in the pipeline, so up to four items can be in flight.
// a synchronous reset empties the pipeline; no item is held over it.
module quad_concave_vertex_finder
   import qcvf_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y from bit 0 up
   input  logic [((2*NUM_CORNERS*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // corner_index in bits 1:0, zeros above
   output logic [7:0] rsp_tdata,
   // found
   output logic rsp_tuser
);

   logic signed [COORD_WIDTH-1:0] px [NUM_CORNERS];
   logic signed [COORD_WIDTH-1:0] py [NUM_CORNERS];
   logic [NUM_CORNERS-1:0] flags;
   qcvf_adv_type adv;
   logic out_adv;
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   qcvf_result_type result;

   always_comb begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
         px[c] = req_tdata[2*c*COORD_WIDTH +: COORD_WIDTH];
         py[c] = req_tdata[(2*c+1)*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   // a stage loads when it is empty or its content moves on
   always_comb begin
      adv.s3 = !v3_ff || out_adv;
      adv.s2 = !v2_ff || adv.s3;
      adv.s1 = !v1_ff || adv.s2;
      v1_in = adv.s1 ? req_tvalid : v1_ff;
      v2_in = adv.s2 ? v1_ff : v2_ff;
      v3_in = adv.s3 ? v2_ff : v3_ff;
   end

   assign req_tready = adv.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_lane
      qcvf_lane #(
         .COORD_WIDTH(COORD_WIDTH)
      ) u_lane (
         .clock(clock),
         .adv(adv),
         .p0_x(px[k]),
         .p0_y(py[k]),
         .p1_x(px[(k + 1) % NUM_CORNERS]),
         .p1_y(py[(k + 1) % NUM_CORNERS]),
         .p2_x(px[(k + 2) % NUM_CORNERS]),
         .p2_y(py[(k + 2) % NUM_CORNERS]),
         .p3_x(px[(k + 3) % NUM_CORNERS]),
         .p3_y(py[(k + 3) % NUM_CORNERS]),
         .flag(flags[k])
      );
   end

   qcvf_merge u_merge (
      .clock(clock),
      .reset(reset),
      .flags(flags),
      .in_valid(v3_ff),
      .out_ready(rsp_tready),
      .advance(out_adv),
      .out_valid(rsp_tvalid),
      .result(result)
   );

   assign rsp_tdata = {{(8-CORNER_IDX_W){1'b0}}, result.corner_index};
   assign rsp_tuser = result.found;

endmodule

@@ rtl/core/qcvf_checker.sv @@
// port-level checks of the concave vertex finder and their binding
module qcvf_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic rsp_tuser
);

   // no corner found means a zero index
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("index not zero without a found corner");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // with the receiver ready throughout, an accepted item comes out
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $past(req_tvalid && req_tready, 4) && $past(rsp_tready, 1) && $past(rsp_tready, 2)
      && $past(rsp_tready, 3) && $past(!reset, 1) && $past(!reset, 2) && $past(!reset, 3)
      && $past(!reset, 4) |-> rsp_tvalid)
      else $error("result item late");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item valid after reset");

endmodule

bind quad_concave_vertex_finder qcvf_checker u_qcvf_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
